FILE: hw/rtl/bor_pkg.sv
`default_nettype none
package bor_pkg;

    // Field widths
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // Derived widths: signed overlap extent, areas, denominator, quotient and numerator
    localparam int EXT_W  = COORD_BITS + 2;
    localparam int AREA_W = 2 * COORD_BITS;
    localparam int DEN_W  = AREA_W + 1;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int NUM_W  = AREA_W + FRAC_BITS;

    // Queue between the classifying front and the dividing back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Mode codes
    localparam logic MODE_IOU = 1'b0;
    localparam logic MODE_IOS = 1'b1;

    // One division job: numerator is inter shifted up by FRAC_BITS
    typedef struct packed {
        logic              hit;
        logic [AREA_W-1:0] inter;
        logic [DEN_W-1:0]  den;
    } t_job;

endpackage
`default_nettype wire

FILE: hw/rtl/bor_front.sv
`default_nettype none
module bor_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_mode,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_a_x,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_a_y,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_a_width,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_a_height,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_b_x,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_b_y,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_b_width,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_b_height,
    output logic                               o_job_valid,
    input  wire logic                          i_job_ready,
    output bor_pkg::t_job                      o_job
);

    localparam int CB = bor_pkg::COORD_BITS;
    localparam int EW = bor_pkg::EXT_W;
    localparam int AW = bor_pkg::AREA_W;
    localparam int DW = bor_pkg::DEN_W;

    logic r_va, r_vb, r_vc;
    logic w_adv;

    // Stage A registers: overlap extents and box sizes
    logic                 r_a_mode;
    logic                 r_a_hit;
    logic [CB-1:0]        r_a_iw, r_a_ih;
    logic [CB-1:0]        r_a_aw, r_a_ah, r_a_bw, r_a_bh;

    // Stage B registers: the three products
    logic                 r_b_mode;
    logic                 r_b_hit;
    logic [AW-1:0]        r_b_inter, r_b_area_a, r_b_area_b;

    // Stage C register: the finished job
    bor_pkg::t_job        r_job;

    logic signed [EW-1:0] n_iw, n_ih;
    logic                 n_hit;
    logic [DW-1:0]        n_den;
    bor_pkg::t_job        n_job;

    // Signed overlap extent on one axis: l1 + l2 - (max end - min start)
    function automatic logic signed [EW-1:0] axis_ext(
        input logic [CB-1:0] p1, input logic [CB-1:0] l1,
        input logic [CB-1:0] p2, input logic [CB-1:0] l2
    );
        logic [CB:0] e1, e2, hi, lo;
        begin
            e1 = {1'b0, p1} + {1'b0, l1};
            e2 = {1'b0, p2} + {1'b0, l2};
            hi = (e1 > e2) ? e1 : e2;
            lo = (p1 < p2) ? {1'b0, p1} : {1'b0, p2};
            axis_ext = $signed({2'b00, l1}) + $signed({2'b00, l2})
                     - $signed({1'b0, hi - lo});
        end
    endfunction

    // The whole front pipeline moves together when its last stage can drain
    assign w_adv   = !r_vc || i_job_ready;
    assign o_ready = w_adv;

    always_comb begin
        n_iw  = axis_ext(i_a_x, i_a_width, i_b_x, i_b_width);
        n_ih  = axis_ext(i_a_y, i_a_height, i_b_y, i_b_height);
        n_hit = !n_iw[EW-1] && (n_iw != '0) && !n_ih[EW-1] && (n_ih != '0);
    end

    // Denominator selection; a miss or an empty denominator divides zero by one
    always_comb begin
        if (r_b_mode == bor_pkg::MODE_IOS) begin
            n_den = (r_b_area_a < r_b_area_b) ? {1'b0, r_b_area_a} : {1'b0, r_b_area_b};
        end else begin
            n_den = {1'b0, r_b_area_a} + {1'b0, r_b_area_b} - {1'b0, r_b_inter};
        end
        n_job.hit = r_b_hit;
        if (!r_b_hit || n_den == '0) begin
            n_job.inter = '0;
            n_job.den   = DW'(1);
        end else begin
            n_job.inter = r_b_inter;
            n_job.den   = n_den;
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (w_adv) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_mode   <= i_mode;
            r_a_hit    <= n_hit;
            r_a_iw     <= n_iw[CB-1:0];
            r_a_ih     <= n_ih[CB-1:0];
            r_a_aw     <= i_a_width;
            r_a_ah     <= i_a_height;
            r_a_bw     <= i_b_width;
            r_a_bh     <= i_b_height;
            r_b_mode   <= r_a_mode;
            r_b_hit    <= r_a_hit;
            r_b_inter  <= r_a_iw * r_a_ih;
            r_b_area_a <= r_a_aw * r_a_ah;
            r_b_area_b <= r_a_bw * r_a_bh;
            r_job      <= n_job;
        end
    end

    assign o_job_valid = r_vc;
    assign o_job       = r_job;

endmodule
`default_nettype wire

FILE: hw/rtl/bor_queue.sv
`default_nettype none
module bor_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bor_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_ready,
    output bor_pkg::t_job      o_job
);

    localparam int PW = bor_pkg::QPTR_W;
    localparam int CW = bor_pkg::QCNT_W;

    bor_pkg::t_job r_mem [bor_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != CW'(bor_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(bor_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(bor_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/bor_div.sv
`default_nettype none
module bor_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire bor_pkg::t_job                i_job,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [bor_pkg::QUO_W-1:0]         o_ratio,
    output logic                              o_overlaps
);

    localparam int QW = bor_pkg::QUO_W;
    localparam int DW = bor_pkg::DEN_W;
    localparam int NW = bor_pkg::NUM_W;

    // One quotient bit is settled in each stage
    typedef struct packed {
        logic          hit;
        logic [DW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] nlow;
        logic [QW-1:0] quo;
    } t_stage;

    logic          r_v  [QW];
    t_stage        r_st [QW];
    t_stage        w_in [QW];
    t_stage        w_out[QW];
    logic [NW-1:0] w_num;
    logic          w_adv;

    assign w_adv   = !r_v[QW-1] || i_ready;
    assign o_ready = w_adv;

    // Quotient stays below 2^QW, so the top numerator bits start as remainder
    always_comb begin
        w_num        = {i_job.inter, {bor_pkg::FRAC_BITS{1'b0}}};
        w_in[0].hit  = i_job.hit;
        w_in[0].rem  = DW'(w_num >> QW);
        w_in[0].den  = i_job.den;
        w_in[0].nlow = w_num[QW-1:0];
        w_in[0].quo  = '0;
        for (int k = 1; k < QW; k++) begin
            w_in[k] = r_st[k-1];
        end
    end

    // Restoring step in each stage
    always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int k = 0; k < QW; k++) begin
            t             = {w_in[k].rem, w_in[k].nlow[QW-1]};
            ge            = (t >= {1'b0, w_in[k].den});
            w_out[k].hit  = w_in[k].hit;
            w_out[k].den  = w_in[k].den;
            w_out[k].rem  = ge ? DW'(t - {1'b0, w_in[k].den}) : DW'(t);
            w_out[k].nlow = {w_in[k].nlow[QW-2:0], 1'b0};
            w_out[k].quo  = {w_in[k].quo[QW-2:0], ge};
        end
    end

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < QW; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < QW; k++) begin
                r_st[k] <= w_out[k];
            end
        end
    end

    assign o_valid    = r_v[QW-1];
    assign o_ratio    = r_st[QW-1].quo;
    assign o_overlaps = r_st[QW-1].hit;

endmodule
`default_nettype wire

FILE: hw/rtl/box_overlap_ratio_top.sv
// Three front stages classify the pair and form the denominator, the queue registers each job,
// and a 17-stage restoring divider settles one quotient bit per stage.
// Throughput: one box pair per cycle while the output is not stalled; the divider stages are fully pipelined.
// Reset: synchronous, active low; it empties every stage and the queue, payload is kept.
`default_nettype none
module box_overlap_ratio_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_mode,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_a_x,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_a_y,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_a_width,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_a_height,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_b_x,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_b_y,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_b_width,
    input  wire logic [bor_pkg::COORD_BITS-1:0] i_b_height,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [bor_pkg::QUO_W-1:0]           o_ratio,
    output logic                                o_overlaps
);

    logic          w_f_valid, w_f_ready;
    bor_pkg::t_job w_f_job;
    logic          w_q_valid, w_q_ready;
    bor_pkg::t_job w_q_job;

    // Front: overlap extents, areas and denominator
    bor_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_a_x       (i_a_x),
        .i_a_y       (i_a_y),
        .i_a_width   (i_a_width),
        .i_a_height  (i_a_height),
        .i_b_x       (i_b_x),
        .i_b_y       (i_b_y),
        .i_b_width   (i_b_width),
        .i_b_height  (i_b_height),
        .o_job_valid (w_f_valid),
        .i_job_ready (w_f_ready),
        .o_job       (w_f_job)
    );

    // Short queue decoupling the two halves
    bor_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_job   (w_f_job),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_job   (w_q_job)
    );

    // Back: pipelined fixed-point divider
    bor_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_job      (w_q_job),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_ratio    (o_ratio),
        .o_overlaps (o_overlaps)
    );

endmodule
`default_nettype wire
